// ----- rtl/pixel_frame_store_core_assert.svh -----
// Assertion macros for the pixel frame store RTL.
`ifndef PIXEL_FRAME_STORE_CORE_ASSERT_SVH
`define PIXEL_FRAME_STORE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pixel frame store assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pixel frame store assertion failed");

`endif

// ----- rtl/pfs_pkg.sv -----
// Package with the types, constants and functions of the pixel frame store.
`timescale 1ns / 1ps
`default_nettype none
package pfs_pkg;

    localparam int MAX_X       = 256;
    localparam int MAX_Y       = 256;
    localparam int STORE_DEPTH = MAX_X * MAX_Y;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int RES_W       = 9;
    localparam int TOT_W       = 2 * RES_W;
    localparam int XI_W        = $clog2(MAX_X);
    localparam int YI_W        = $clog2(MAX_Y);
    localparam int POS_W       = 16;
    localparam int VAL_W       = 16;
    localparam int DEPTH_W     = 32;
    localparam int FIELD_W     = 12;
    localparam int BYTE_W      = 8;
    localparam int PIXEL_W     = 5 * FIELD_W;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;

    localparam logic [FIELD_W-1:0] CLEAR_COLOUR = FIELD_W'(3000);
    localparam logic [FIELD_W-1:0] CLEAR_ALPHA  = FIELD_W'(1);
    localparam logic [FIELD_W-1:0] FIELD_MAX    = FIELD_W'(4095);
    localparam logic [RES_W-1:0]   RES_RESET    = RES_W'(256);
    localparam logic [RES_W-1:0]   MAX_X_RES    = RES_W'(MAX_X);
    localparam logic [RES_W-1:0]   MAX_Y_RES    = RES_W'(MAX_Y);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic exec_mem;
        logic clr_start;
        logic clr_step;
        logic load_res;
        logic res_from_ram;
    } t_ctrl_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic in_range;
        logic clr_empty;
        logic clr_last;
    } t_dp_status;

    function automatic logic [FIELD_W-1:0] clamp_field(input logic signed [DEPTH_W-1:0] v);
        logic [FIELD_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > DEPTH_W'(FIELD_MAX)) begin
            res = FIELD_MAX;
        end else begin
            res = v[FIELD_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pfs_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pfs_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/pfs_datapath.sv -----
// Datapath: request registers, bounds check, address, clear counter, store and result.
`timescale 1ns / 1ps
`default_nettype none
module pfs_datapath (
    input  wire logic                            i_clk,
    input  wire pfs_pkg::t_ctrl_cmd              i_ctrl,
    output pfs_pkg::t_dp_status                  o_status_dp,
    input  wire logic [pfs_pkg::RES_W-1:0]       i_x_res,
    input  wire logic [pfs_pkg::RES_W-1:0]       i_y_res,
    input  wire logic [1:0]                      i_cmd,
    input  wire logic signed [pfs_pkg::POS_W-1:0]   i_x_pos,
    input  wire logic signed [pfs_pkg::POS_W-1:0]   i_y_pos,
    input  wire logic signed [pfs_pkg::VAL_W-1:0]   i_red_in,
    input  wire logic signed [pfs_pkg::VAL_W-1:0]   i_green_in,
    input  wire logic signed [pfs_pkg::VAL_W-1:0]   i_blue_in,
    input  wire logic signed [pfs_pkg::VAL_W-1:0]   i_alpha_in,
    input  wire logic signed [pfs_pkg::DEPTH_W-1:0] i_depth_in,
    output logic                                 o_status,
    output logic [pfs_pkg::FIELD_W-1:0]          o_red_out,
    output logic [pfs_pkg::FIELD_W-1:0]          o_green_out,
    output logic [pfs_pkg::FIELD_W-1:0]          o_blue_out,
    output logic [pfs_pkg::FIELD_W-1:0]          o_alpha_out,
    output logic [pfs_pkg::FIELD_W-1:0]          o_depth_out,
    output logic [pfs_pkg::BYTE_W-1:0]           o_red_byte,
    output logic [pfs_pkg::BYTE_W-1:0]           o_green_byte,
    output logic [pfs_pkg::BYTE_W-1:0]           o_blue_byte
);
    import pfs_pkg::*;

    localparam int PROD_W = YI_W + RES_W;

    t_cmd                       r_cmd;
    logic signed [POS_W-1:0]    r_x;
    logic signed [POS_W-1:0]    r_y;
    logic signed [VAL_W-1:0]    r_red;
    logic signed [VAL_W-1:0]    r_green;
    logic signed [VAL_W-1:0]    r_blue;
    logic signed [VAL_W-1:0]    r_alpha;
    logic signed [DEPTH_W-1:0]  r_depth;
    logic [TOT_W-1:0]           r_total;
    logic [TOT_W-1:0]           r_clr_idx;
    logic                       r_res_status;
    logic [PIXEL_W-1:0]         r_res_pix;

    logic [RES_W-1:0]   xe;
    logic [RES_W-1:0]   ye;
    logic               in_range;
    logic [PROD_W-1:0]  prod;
    logic [ADDR_W-1:0]  idx;
    logic [TOT_W-1:0]   total;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_addr;
    logic [PIXEL_W-1:0] ram_wdata;
    logic [PIXEL_W-1:0] ram_rdata;
    logic [PIXEL_W-1:0] wr_pix;
    logic [PIXEL_W-1:0] fill_pix;
    logic               exec_status;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_x     <= i_x_pos;
            r_y     <= i_y_pos;
            r_red   <= i_red_in;
            r_green <= i_green_in;
            r_blue  <= i_blue_in;
            r_alpha <= i_alpha_in;
            r_depth <= i_depth_in;
        end
    end

    always_comb begin
        xe = (i_x_res > MAX_X_RES) ? MAX_X_RES : i_x_res;
        ye = (i_y_res > MAX_Y_RES) ? MAX_Y_RES : i_y_res;
        in_range = !r_x[POS_W-1] && !r_y[POS_W-1]
                   && (r_x[POS_W-2:0] < (POS_W-1)'(xe))
                   && (r_y[POS_W-2:0] < (POS_W-1)'(ye));
        prod  = PROD_W'(r_y[YI_W-1:0]) * PROD_W'(xe);
        idx   = ADDR_W'(prod + PROD_W'(r_x[XI_W-1:0]));
        total = TOT_W'(xe) * TOT_W'(ye);
        exec_status = ((r_cmd == CMD_WRITE) || (r_cmd == CMD_READ)) && !in_range;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr_start) begin
            r_total   <= total;
            r_clr_idx <= '0;
        end else if (i_ctrl.clr_step) begin
            r_clr_idx <= r_clr_idx + TOT_W'(1);
        end
    end

    assign fill_pix = {FIELD_W'(0), CLEAR_ALPHA, CLEAR_COLOUR, CLEAR_COLOUR, CLEAR_COLOUR};
    assign wr_pix   = {clamp_field(r_depth),
                       clamp_field(DEPTH_W'(r_alpha)),
                       clamp_field(DEPTH_W'(r_blue)),
                       clamp_field(DEPTH_W'(r_green)),
                       clamp_field(DEPTH_W'(r_red))};

    always_comb begin
        ram_we    = i_ctrl.clr_step
                    || (i_ctrl.exec_mem && (r_cmd == CMD_WRITE) && in_range);
        ram_re    = i_ctrl.exec_mem && (r_cmd == CMD_READ) && in_range;
        ram_addr  = i_ctrl.clr_step ? r_clr_idx[ADDR_W-1:0] : idx;
        ram_wdata = i_ctrl.clr_step ? fill_pix : wr_pix;
    end

    pfs_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_res) begin
            if (i_ctrl.res_from_ram) begin
                r_res_status <= 1'b0;
                r_res_pix    <= ram_rdata;
            end else begin
                r_res_status <= exec_status;
                r_res_pix    <= '0;
            end
        end
    end

    assign o_status_dp.cmd       = r_cmd;
    assign o_status_dp.in_range  = in_range;
    assign o_status_dp.clr_empty = (total == '0);
    assign o_status_dp.clr_last  = ((r_clr_idx + TOT_W'(1)) == r_total);

    assign o_status     = r_res_status;
    assign o_red_out    = r_res_pix[FIELD_W-1:0];
    assign o_green_out  = r_res_pix[2*FIELD_W-1:FIELD_W];
    assign o_blue_out   = r_res_pix[3*FIELD_W-1:2*FIELD_W];
    assign o_alpha_out  = r_res_pix[4*FIELD_W-1:3*FIELD_W];
    assign o_depth_out  = r_res_pix[5*FIELD_W-1:4*FIELD_W];
    assign o_red_byte   = r_res_pix[FIELD_W-1:FIELD_W-BYTE_W];
    assign o_green_byte = r_res_pix[2*FIELD_W-1:2*FIELD_W-BYTE_W];
    assign o_blue_byte  = r_res_pix[3*FIELD_W-1:3*FIELD_W-BYTE_W];

endmodule
`default_nettype wire

// ----- rtl/pfs_ctrl.sv -----
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_frame_store_core_assert.svh"
module pfs_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire pfs_pkg::t_dp_status  i_status_dp,
    output pfs_pkg::t_ctrl_cmd        o_ctrl,
    output logic                      o_busy,
    output logic                      o_valid
);
    import pfs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE, S_DONE: begin
                n_state = i_start ? S_EXEC : S_IDLE;
            end
            S_EXEC: begin
                unique case (i_status_dp.cmd)
                    CMD_CLEAR: n_state = i_status_dp.clr_empty ? S_DONE : S_CLEAR;
                    CMD_READ:  n_state = i_status_dp.in_range ? S_READ : S_DONE;
                    default:   n_state = S_DONE;
                endcase
            end
            S_CLEAR: begin
                n_state = i_status_dp.clr_last ? S_DONE : S_CLEAR;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl  = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy         = 1'b0;
                o_ctrl.load_in = i_start;
            end
            S_DONE: begin
                o_busy         = 1'b0;
                o_valid        = 1'b1;
                o_ctrl.load_in = i_start;
            end
            S_EXEC: begin
                o_ctrl.exec_mem  = 1'b1;
                o_ctrl.clr_start = 1'b1;
                o_ctrl.load_res  = !((i_status_dp.cmd == CMD_CLEAR) && !i_status_dp.clr_empty)
                                   && !((i_status_dp.cmd == CMD_READ) && i_status_dp.in_range);
            end
            S_CLEAR: begin
                o_ctrl.clr_step = 1'b1;
                o_ctrl.load_res = i_status_dp.clr_last;
            end
            S_READ: begin
                o_ctrl.load_res     = 1'b1;
                o_ctrl.res_from_ram = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    `PFS_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, accept, r_state == S_EXEC)
    `PFS_ASSERT_NXT(a_read_result, i_clk, i_rst_n, r_state == S_READ, o_valid)
    `PFS_ASSERT_NXT(a_exec_once, i_clk, i_rst_n, r_state == S_EXEC, r_state != S_EXEC)
    `PFS_ASSERT_IMP(a_clear_no_load, i_clk, i_rst_n, o_ctrl.clr_step, !o_ctrl.load_in && o_busy)

endmodule
`default_nettype wire

// ----- rtl/pixel_frame_store_core.sv -----
// Pixel frame store with depth: a 1-bit status and 12-bit field results per request.
// Each accepted request passes EXEC and ends in DONE, where its result is strobed: writes,
// ignored and rejected requests load their result in EXEC, an in-range read passes READ
// for the registered store data, and a clear fills one store entry per cycle in CLEAR over
// the active area (x_res and y_res each capped at 256), or skips CLEAR if that is empty.
// A new request is taken in the cycle its predecessor's result is strobed, and not before.
// Synchronous reset returns the controller to idle and x_res, y_res to 256; store contents
// stay undefined until cleared or written. The receiver cannot stall the result strobe.
`timescale 1ns / 1ps
`default_nettype none
module pixel_frame_store_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic [1:0]                          i_cmd,
    input  wire logic signed [pfs_pkg::POS_W-1:0]    i_x_pos,
    input  wire logic signed [pfs_pkg::POS_W-1:0]    i_y_pos,
    input  wire logic signed [pfs_pkg::VAL_W-1:0]    i_red_in,
    input  wire logic signed [pfs_pkg::VAL_W-1:0]    i_green_in,
    input  wire logic signed [pfs_pkg::VAL_W-1:0]    i_blue_in,
    input  wire logic signed [pfs_pkg::VAL_W-1:0]    i_alpha_in,
    input  wire logic signed [pfs_pkg::DEPTH_W-1:0]  i_depth_in,
    output logic                                     o_valid,
    output logic                                     o_status,
    output logic [pfs_pkg::FIELD_W-1:0]              o_red_out,
    output logic [pfs_pkg::FIELD_W-1:0]              o_green_out,
    output logic [pfs_pkg::FIELD_W-1:0]              o_blue_out,
    output logic [pfs_pkg::FIELD_W-1:0]              o_alpha_out,
    output logic [pfs_pkg::FIELD_W-1:0]              o_depth_out,
    output logic [pfs_pkg::BYTE_W-1:0]               o_red_byte,
    output logic [pfs_pkg::BYTE_W-1:0]               o_green_byte,
    output logic [pfs_pkg::BYTE_W-1:0]               o_blue_byte,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pfs_pkg::APB_AW-1:0]          paddr,
    input  wire logic [pfs_pkg::APB_DW-1:0]          pwdata,
    output logic [pfs_pkg::APB_DW-1:0]               prdata,
    output logic                                     pready
);
    import pfs_pkg::*;

    logic [RES_W-1:0] r_x_res;
    logic [RES_W-1:0] r_y_res;
    logic             cfg_we;
    t_ctrl_cmd        ctrl;
    t_dp_status       status_dp;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_res <= RES_RESET;
            r_y_res <= RES_RESET;
        end else if (cfg_we) begin
            if (paddr[2]) begin
                r_y_res <= pwdata[RES_W-1:0];
            end else begin
                r_x_res <= pwdata[RES_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? APB_DW'(r_y_res) : APB_DW'(r_x_res);

    pfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_status_dp (status_dp),
        .o_ctrl      (ctrl),
        .o_busy      (o_busy),
        .o_valid     (o_valid)
    );

    pfs_datapath u_datapath (
        .i_clk        (i_clk),
        .i_ctrl       (ctrl),
        .o_status_dp  (status_dp),
        .i_x_res      (r_x_res),
        .i_y_res      (r_y_res),
        .i_cmd        (i_cmd),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_alpha_in   (i_alpha_in),
        .i_depth_in   (i_depth_in),
        .o_status     (o_status),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_alpha_out  (o_alpha_out),
        .o_depth_out  (o_depth_out),
        .o_red_byte   (o_red_byte),
        .o_green_byte (o_green_byte),
        .o_blue_byte  (o_blue_byte)
    );

endmodule
`default_nettype wire
